// ===== rtl/core/dbg_pkt_pkg.sv =====
// shared types, constants and helpers for the debug packet receiver
package dbg_pkt_pkg;

    localparam int unsigned CHAR_W   = 8;
    localparam int unsigned COUNT_W  = 9;
    localparam int unsigned KIND_W   = 2;
    localparam int unsigned M_DATA_W = 24;

    // longest body before a reject, a frame keeps one byte fewer
    localparam logic [COUNT_W-1:0] MAX_PAYLOAD = 9'd256;

    localparam logic [CHAR_W-1:0] CH_START = 8'h24;
    localparam logic [CHAR_W-1:0] CH_END   = 8'h23;
    localparam logic [CHAR_W-1:0] CH_ESC   = 8'h7D;
    localparam logic [CHAR_W-1:0] CH_ACK   = 8'h2B;
    localparam logic [CHAR_W-1:0] CH_NAK   = 8'h2D;
    localparam logic [CHAR_W-1:0] ESC_XOR  = 8'h20;

    typedef logic [KIND_W-1:0] t_kind;

    localparam t_kind KIND_BYTE    = 2'd0;
    localparam t_kind KIND_RESTART = 2'd1;
    localparam t_kind KIND_ACCEPT  = 2'd2;
    localparam t_kind KIND_REJECT  = 2'd3;

    // lower-case hex digit character for a nibble
    function automatic logic [CHAR_W-1:0] nibble_char(input logic [3:0] n);
        logic [CHAR_W-1:0] wide;
        begin
            wide = {4'd0, n};
            if (n < 4'd10) begin
                nibble_char = 8'h30 + wide;
            end else begin
                nibble_char = 8'h57 + wide;
            end
        end
    endfunction

endpackage

// ===== rtl/core/debug_packet_receiver.sv =====
// debug packet receiver: deframes "$body#cs" packets from a serial character stream
//
// One received character per input item, one item accepted every clock cycle
// unless a stalled result holds the input side. An item passes an input register
// and then a result register before its result is offered; the frame state is
// updated at the same edge as the result register.
// Payload bytes come out as soon as they are decoded and
// stay tentative until the frame ends: kind 1 says drop the bytes so far,
// kind 2 carries '+' and the length, kind 3 carries '-'. A frame holds at most
// MAX_PAYLOAD-1 bytes; the next one rejects it.
module debug_packet_receiver (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] value, [16:8] payload_length, zero fill
    output logic [1:0]  m_axis_tuser    // [1:0] kind
);

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_BODY = 2'd1;
    localparam logic [1:0] PH_HI   = 2'd2;
    localparam logic [1:0] PH_LO   = 2'd3;

    localparam int unsigned CW = dbg_pkt_pkg::CHAR_W;
    localparam int unsigned NW = dbg_pkt_pkg::COUNT_W;

    logic                  r_in_valid;
    logic [CW-1:0]         r_in_char;

    logic [1:0]            r_phase,  n_phase;
    logic [CW-1:0]         r_sum,    n_sum;
    logic                  r_esc,    n_esc;
    logic [NW-1:0]         r_count,  n_count;

    logic                  r_out_valid;
    dbg_pkt_pkg::t_kind    r_out_kind;
    logic [CW-1:0]         r_out_value;
    logic [NW-1:0]         r_out_len;

    logic                  res_valid;
    dbg_pkt_pkg::t_kind    res_kind;
    logic [CW-1:0]         res_value;
    logic [NW-1:0]         res_len;

    logic                  out_free;
    logic                  process;
    logic [NW-1:0]         count_inc;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign process       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign count_inc     = r_count + NW'(1);

    always_comb begin
        n_phase   = r_phase;
        n_sum     = r_sum;
        n_esc     = r_esc;
        n_count   = r_count;
        res_valid = 1'b0;
        res_kind  = dbg_pkt_pkg::KIND_BYTE;
        res_value = '0;
        res_len   = '0;
        case (r_phase)
            PH_IDLE: begin
                if (r_in_char == dbg_pkt_pkg::CH_START) begin
                    n_sum   = '0;
                    n_esc   = 1'b0;
                    n_count = '0;
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (r_in_char == dbg_pkt_pkg::CH_START) begin
                    n_sum     = '0;
                    n_esc     = 1'b0;
                    n_count   = '0;
                    res_valid = 1'b1;
                    res_kind  = dbg_pkt_pkg::KIND_RESTART;
                end else if (r_in_char == dbg_pkt_pkg::CH_END) begin
                    n_phase = PH_HI;
                end else if (r_in_char == dbg_pkt_pkg::CH_ESC) begin
                    n_sum = r_sum + r_in_char;
                    n_esc = 1'b1;
                end else if (count_inc >= dbg_pkt_pkg::MAX_PAYLOAD) begin
                    n_phase   = PH_IDLE;
                    n_sum     = '0;
                    n_esc     = 1'b0;
                    n_count   = '0;
                    res_valid = 1'b1;
                    res_kind  = dbg_pkt_pkg::KIND_REJECT;
                    res_value = dbg_pkt_pkg::CH_NAK;
                end else begin
                    n_sum     = r_sum + r_in_char;
                    n_esc     = 1'b0;
                    n_count   = count_inc;
                    res_valid = 1'b1;
                    res_kind  = dbg_pkt_pkg::KIND_BYTE;
                    res_value = r_esc ? (r_in_char ^ dbg_pkt_pkg::ESC_XOR) : r_in_char;
                end
            end
            PH_HI: begin
                if (r_in_char != dbg_pkt_pkg::nibble_char(r_sum[7:4])) begin
                    n_phase   = PH_IDLE;
                    n_sum     = '0;
                    n_esc     = 1'b0;
                    n_count   = '0;
                    res_valid = 1'b1;
                    res_kind  = dbg_pkt_pkg::KIND_REJECT;
                    res_value = dbg_pkt_pkg::CH_NAK;
                end else begin
                    n_phase = PH_LO;
                end
            end
            default: begin
                n_phase   = PH_IDLE;
                n_sum     = '0;
                n_esc     = 1'b0;
                n_count   = '0;
                res_valid = 1'b1;
                if (r_in_char == dbg_pkt_pkg::nibble_char(r_sum[3:0])) begin
                    res_kind  = dbg_pkt_pkg::KIND_ACCEPT;
                    res_value = dbg_pkt_pkg::CH_ACK;
                    res_len   = r_count;
                end else begin
                    res_kind  = dbg_pkt_pkg::KIND_REJECT;
                    res_value = dbg_pkt_pkg::CH_NAK;
                end
            end
        endcase
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_char <= s_axis_tdata;
        end
    end

    // frame state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_sum   <= '0;
            r_esc   <= 1'b0;
            r_count <= '0;
        end else if (process) begin
            r_phase <= n_phase;
            r_sum   <= n_sum;
            r_esc   <= n_esc;
            r_count <= n_count;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= process && res_valid;
        end
        if (process && res_valid) begin
            r_out_kind  <= res_kind;
            r_out_value <= res_value;
            r_out_len   <= res_len;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_kind;
    assign m_axis_tdata  = {{(dbg_pkt_pkg::M_DATA_W - NW - CW){1'b0}}, r_out_len, r_out_value};

endmodule

// ===== rtl/core/dbg_pkt_checker.sv =====
// port checker for the debug packet receiver, bound to the top level
module dbg_pkt_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // only an accept carries a length
    a_len_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != dbg_pkt_pkg::KIND_ACCEPT |->
            m_axis_tdata[16:8] == 9'd0)
        else $error("length on a non-accept item");

    // accept carries ack and a length below the limit
    a_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == dbg_pkt_pkg::KIND_ACCEPT |->
            m_axis_tdata[7:0] == dbg_pkt_pkg::CH_ACK
            && m_axis_tdata[16:8] < dbg_pkt_pkg::MAX_PAYLOAD)
        else $error("bad accept item");

    // reject carries nak, restart carries zero
    a_reject_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != dbg_pkt_pkg::KIND_BYTE
            && m_axis_tuser != dbg_pkt_pkg::KIND_ACCEPT |->
            (m_axis_tuser == dbg_pkt_pkg::KIND_REJECT
                && m_axis_tdata[7:0] == dbg_pkt_pkg::CH_NAK)
            || (m_axis_tuser == dbg_pkt_pkg::KIND_RESTART
                && m_axis_tdata[7:0] == 8'd0))
        else $error("bad reject or restart item");

endmodule

bind debug_packet_receiver dbg_pkt_checker u_dbg_pkt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb_debug_packet_receiver.sv =====
// testbench for the debug packet receiver: framed character streams checked against a predictor
`timescale 1ns / 100ps

module tb_debug_packet_receiver;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_BODY,
        PH_CS_HI,
        PH_CS_LO
    } t_rx_phase;

    typedef struct packed {
        dbg_pkt_pkg::t_kind              kind;
        logic [dbg_pkt_pkg::CHAR_W-1:0]  value;
        logic [dbg_pkt_pkg::COUNT_W-1:0] len;
    } t_pkt_result;

    localparam int unsigned TOTAL_ITEMS = 950;

    logic               i_clk         = 1'b0;
    logic               i_rst_n       = 1'b0;
    logic               s_axis_tvalid = 1'b0;
    logic [7:0]         s_axis_tdata  = 8'h00;
    logic               m_axis_tready = 1'b0;
    wire                s_axis_tready;
    wire                m_axis_tvalid;
    wire [23:0]         m_axis_tdata;   // [7:0] value, [16:8] payload_length, zero fill
    wire [1:0]          m_axis_tuser;   // [1:0] kind

    // predictor state
    t_rx_phase          rx_phase      = PH_HUNT;
    logic [7:0]         body_sum      = 8'h00;
    logic               esc_armed     = 1'b0;
    logic [dbg_pkt_pkg::COUNT_W-1:0] payload_count = '0;
    t_pkt_result        pending_results[$];

    bit                 tx_no_gaps    = 1'b0;
    bit                 rx_no_stalls  = 1'b0;
    int unsigned        error_count   = 0;
    int unsigned        active_items  = 0;
    int unsigned        chars_sent    = 0;
    int unsigned        bytes_seen    = 0;
    int unsigned        restarts_seen = 0;
    int unsigned        acks_seen     = 0;
    int unsigned        naks_seen     = 0;

    debug_packet_receiver dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        if (nib > 4'd9) begin
            return 8'h61 + 8'(nib) - 8'd10;
        end
        return 8'h30 + 8'(nib);
    endfunction

    function automatic void clear_frame();
        body_sum      = 8'h00;
        esc_armed     = 1'b0;
        payload_count = '0;
    endfunction

    function automatic void queue_result(input dbg_pkt_pkg::t_kind kind,
                                         input logic [7:0] value,
                                         input logic [dbg_pkt_pkg::COUNT_W-1:0] len);
        t_pkt_result r;
        r.kind  = kind;
        r.value = value;
        r.len   = len;
        pending_results.push_back(r);
    endfunction

    function automatic void deframe_char(input logic [7:0] ch);
        case (rx_phase)
            PH_HUNT: begin
                if (ch == dbg_pkt_pkg::CH_START) begin
                    clear_frame();
                    rx_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (ch == dbg_pkt_pkg::CH_START) begin
                    clear_frame();
                    queue_result(dbg_pkt_pkg::KIND_RESTART, 8'h00, '0);
                end else if (ch == dbg_pkt_pkg::CH_END) begin
                    rx_phase = PH_CS_HI;
                end else begin
                    body_sum = body_sum + ch;
                    if (ch == dbg_pkt_pkg::CH_ESC) begin
                        esc_armed = 1'b1;
                    end else begin
                        payload_count = payload_count + 9'd1;
                        if (payload_count >= dbg_pkt_pkg::MAX_PAYLOAD) begin
                            rx_phase = PH_HUNT;
                            clear_frame();
                            queue_result(dbg_pkt_pkg::KIND_REJECT, dbg_pkt_pkg::CH_NAK, '0);
                        end else begin
                            queue_result(dbg_pkt_pkg::KIND_BYTE,
                                         esc_armed ? (ch ^ dbg_pkt_pkg::ESC_XOR) : ch, '0);
                        end
                        esc_armed = 1'b0;
                    end
                end
            end
            PH_CS_HI: begin
                if (ch != hex_digit(body_sum[7:4])) begin
                    rx_phase = PH_HUNT;
                    clear_frame();
                    queue_result(dbg_pkt_pkg::KIND_REJECT, dbg_pkt_pkg::CH_NAK, '0);
                end else begin
                    rx_phase = PH_CS_LO;
                end
            end
            default: begin
                if (ch == hex_digit(body_sum[3:0])) begin
                    queue_result(dbg_pkt_pkg::KIND_ACCEPT, dbg_pkt_pkg::CH_ACK, payload_count);
                end else begin
                    queue_result(dbg_pkt_pkg::KIND_REJECT, dbg_pkt_pkg::CH_NAK, '0);
                end
                rx_phase = PH_HUNT;
                clear_frame();
            end
        endcase
    endfunction

    // any character except the framing and escape markers
    function automatic logic [7:0] plain_char();
        logic [7:0] c;
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == dbg_pkt_pkg::CH_START || c == dbg_pkt_pkg::CH_END
                   || c == dbg_pkt_pkg::CH_ESC);
        return c;
    endfunction

    // a wrong checksum digit, sometimes the upper-case form of the right one
    function automatic logic [7:0] wrong_digit(input logic [7:0] good);
        logic [7:0] c;
        if (good >= 8'h61 && $urandom_range(0, 1) == 0) begin
            return good - 8'h20;
        end
        do begin
            c = 8'($urandom_range(0, 255));
        end while (c == good);
        return c;
    endfunction

    task automatic send_char(input logic [7:0] ch);
        int unsigned gap;
        gap = tx_no_gaps ? 0 : $urandom_range(0, 12);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= ch;
        do begin
            @(posedge i_clk);
        end while (!s_axis_tready);
        if (rx_phase != PH_HUNT || ch == dbg_pkt_pkg::CH_START) begin
            active_items++;
        end
        chars_sent++;
        deframe_char(ch);
    endtask

    task automatic wait_for_drain(input int unsigned settle);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (settle) @(posedge i_clk);
    endtask

    // bad_digit: 0 good checksum, 1 wrong high digit, 2 wrong low digit
    task automatic send_frame(input int unsigned nbytes, input int unsigned bad_digit);
        logic [7:0] sum;
        logic [7:0] ch;
        logic [7:0] hi;
        logic [7:0] lo;
        sum = 8'h00;
        send_char(dbg_pkt_pkg::CH_START);
        for (int unsigned i = 0; i < nbytes; i++) begin
            if ($urandom_range(0, 7) == 0) begin
                send_char(dbg_pkt_pkg::CH_ESC);
                sum = sum + dbg_pkt_pkg::CH_ESC;
            end
            ch = plain_char();
            send_char(ch);
            sum = sum + ch;
        end
        send_char(dbg_pkt_pkg::CH_END);
        hi = hex_digit(sum[7:4]);
        lo = hex_digit(sum[3:0]);
        if (bad_digit == 1) begin
            hi = wrong_digit(hi);
        end else if (bad_digit == 2) begin
            lo = wrong_digit(lo);
        end
        send_char(hi);
        if (bad_digit != 1) begin
            send_char(lo);
        end
    endtask

    task automatic test_idle_noise();
        send_char(8'h00);
        send_char(8'hFF);
        send_char(dbg_pkt_pkg::CH_END);
        send_char(dbg_pkt_pkg::CH_ESC);
    endtask

    task automatic test_restart_and_escapes();
        send_char(dbg_pkt_pkg::CH_START);
        send_char(dbg_pkt_pkg::CH_START);
        send_char(8'h41);
        send_char(dbg_pkt_pkg::CH_ESC);
        send_char(8'h5D);
        send_char(dbg_pkt_pkg::CH_ESC);
        send_char(dbg_pkt_pkg::CH_ESC);
        send_char(8'h01);
        send_char(dbg_pkt_pkg::CH_ESC);
        send_char(dbg_pkt_pkg::CH_START);
        send_char(8'h00);
        send_char(8'hFF);
        send_char(dbg_pkt_pkg::CH_ESC);
        send_char(dbg_pkt_pkg::CH_END);
        send_char(hex_digit(body_sum[7:4]));
        send_char(hex_digit(body_sum[3:0]));
    endtask

    task automatic test_checksum_errors();
        // empty frame
        send_char(dbg_pkt_pkg::CH_START);
        send_char(dbg_pkt_pkg::CH_END);
        send_char(8'h30);
        send_char(8'h30);
        // wrong high digit
        send_char(dbg_pkt_pkg::CH_START);
        send_char(dbg_pkt_pkg::CH_END);
        send_char(8'h41);
        // start marker as low digit is only a mismatch
        send_char(dbg_pkt_pkg::CH_START);
        send_char(dbg_pkt_pkg::CH_END);
        send_char(8'h30);
        send_char(dbg_pkt_pkg::CH_START);
        // upper-case digit
        send_char(dbg_pkt_pkg::CH_START);
        send_char(8'h6B);
        send_char(dbg_pkt_pkg::CH_END);
        send_char(8'h36);
        send_char(8'h42);
    endtask

    task automatic test_overlong_body();
        send_frame(dbg_pkt_pkg::MAX_PAYLOAD - 1, 0);
        send_frame(dbg_pkt_pkg::MAX_PAYLOAD, 0);
        wait_for_drain(8);
    endtask

    task automatic test_random_traffic();
        int unsigned frame_no;
        int unsigned pick;
        int unsigned nbytes;
        frame_no = 0;
        while (chars_sent < TOTAL_ITEMS) begin
            if (frame_no % 8 == 0) begin
                tx_no_gaps   = ($urandom_range(0, 3) == 0);
                rx_no_stalls = ($urandom_range(0, 3) == 0);
            end
            if (frame_no % 10 == 9) begin
                wait_for_drain(8);
            end
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
                nbytes = $urandom_range(240, 270);
            end else if (pick < 10) begin
                nbytes = $urandom_range(17, 80);
            end else begin
                nbytes = $urandom_range(0, 16);
            end
            pick = $urandom_range(0, 99);
            if (pick < 10) begin
                repeat ($urandom_range(1, 4)) send_char(8'($urandom_range(0, 255)));
            end else if (pick < 20) begin
                // partial frame cut short by the next start marker
                send_char(dbg_pkt_pkg::CH_START);
                repeat ($urandom_range(0, 5)) send_char(plain_char());
                send_frame(nbytes, 0);
            end else if (pick < 30) begin
                send_frame(nbytes, $urandom_range(1, 2));
            end else begin
                send_frame(nbytes, 0);
            end
            frame_no++;
        end
        tx_no_gaps   = 1'b0;
        rx_no_stalls = 1'b0;
    endtask

    initial begin
        int unsigned stall;
        t_pkt_result want;
        wait (i_rst_n);
        forever begin
            stall = rx_no_stalls ? 0 : $urandom_range(0, 12);
            if (stall > 0) begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do begin
                @(posedge i_clk);
            end while (!m_axis_tvalid);
            case (dbg_pkt_pkg::t_kind'(m_axis_tuser))
                dbg_pkt_pkg::KIND_BYTE:    bytes_seen++;
                dbg_pkt_pkg::KIND_RESTART: restarts_seen++;
                dbg_pkt_pkg::KIND_ACCEPT:  acks_seen++;
                default:                   naks_seen++;
            endcase
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected item kind %0d tdata %h", $time, m_axis_tuser,
                         m_axis_tdata);
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (m_axis_tuser != want.kind) begin
                    $display("%0t: kind expected %0d actual %0d", $time, want.kind,
                             m_axis_tuser);
                    error_count++;
                end
                if (m_axis_tdata[7:0] != want.value) begin
                    $display("%0t: value expected %h actual %h", $time, want.value,
                             m_axis_tdata[7:0]);
                    error_count++;
                end
                if (m_axis_tdata[16:8] != want.len) begin
                    $display("%0t: payload_length expected %0d actual %0d", $time, want.len,
                             m_axis_tdata[16:8]);
                    error_count++;
                end
            end
        end
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_idle_noise();
        test_restart_and_escapes();
        test_checksum_errors();
        test_overlong_body();
        test_random_traffic();
        wait_for_drain(10);
        $display("%0d characters sent, %0d inside frames", chars_sent, active_items);
        $display("results: %0d bytes, %0d restarts, %0d accepted, %0d rejected",
                 bytes_seen, restarts_seen, acks_seen, naks_seen);
        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/dbg_pkt_pkg.sv
rtl/core/debug_packet_receiver.sv
rtl/core/dbg_pkt_checker.sv
tb/tb_debug_packet_receiver.sv
